### rtl/ows_pkg.sv
`default_nettype none

package ows_pkg;

    localparam int unsigned TIMER_W        = 10;
    localparam int unsigned PRESENCE_TRIES = 4;
    localparam int unsigned READ_LOW_TICKS = 2;

    // command codes
    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_RESET      = 3'd1;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd3;
    localparam logic [2:0] CMD_READ_BIT   = 3'd4;
    localparam logic [2:0] CMD_WRITE_BIT  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [2:0] CFG_PRES_INTERVAL = 3'd1;
    localparam logic [2:0] CFG_PRES_RECOVERY = 3'd2;
    localparam logic [2:0] CFG_W0_LOW        = 3'd3;
    localparam logic [2:0] CFG_W1_LOW        = 3'd4;
    localparam logic [2:0] CFG_W1_TAIL       = 3'd5;
    localparam logic [2:0] CFG_RD_SAMPLE     = 3'd6;
    localparam logic [2:0] CFG_RD_TAIL       = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_PRES_WAIT = 4'd2,
        PH_PRES_REC  = 4'd3,
        PH_W0_LOW    = 4'd4,
        PH_W1_LOW    = 4'd5,
        PH_W1_TAIL   = 4'd6,
        PH_RD_LOW    = 4'd7,
        PH_RD_WAIT   = 4'd8,
        PH_RD_TAIL   = 4'd9
    } t_phase;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [7:0] presence_interval_ticks;
        logic [9:0] presence_recovery_ticks;
        logic [7:0] write_zero_low_ticks;
        logic [7:0] write_one_low_ticks;
        logic [7:0] write_one_tail_ticks;
        logic [7:0] read_sample_ticks;
        logic [7:0] read_tail_ticks;
    } t_cfg;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
    } t_result;

    // a count of zero behaves as one
    function automatic logic [TIMER_W-1:0] span(input logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

### rtl/one_wire_master_sequencer.sv
// One-wire bus master sequencer, advanced by one tick transfer.
// Input channel (i_in_valid / o_in_ready): one transfer per bus tick, carrying
//   the sampled line level and an optional command (reset with presence
//   detect, write bit/byte, read bit/byte). Commands while busy are dropped.
// Output channel (o_out_valid / i_out_ready): exactly one result transfer per
//   input transfer: drive_low for that tick, busy/done flags, the presence
//   result of the last reset and the last byte or bit read (LSB first).
// Timing: a tick is captured in an input register, stepped through the
//   sequencer logic and lands in the output register, where its result is
//   offered. One tick per cycle is sustained while the receiver takes
//   results, since the step from input register to output register is
//   combinational.
// Stall: when the receiver holds i_out_ready low with a result waiting, the
//   pipe holds; one more tick is still taken into the input register, then
//   o_in_ready drops until the result moves on.
// Reset (i_rst_n low, synchronous): sequencer idle, flags and read data
//   cleared, timing registers back to their defaults, both stages empty.
// Config: i_cfg_we writes register i_cfg_index with i_cfg_data at once;
//   write only while no command is running.
`default_nettype none

module one_wire_master_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick input
    input  wire logic        i_in_valid,
    output wire logic        o_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_bus_level,
    // result output
    output wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    output wire logic        o_drive_low,
    output wire logic        o_busy_res,
    output wire logic        o_done_res,
    output wire logic        o_presence,
    output wire logic [7:0]  o_read_data,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);
    import ows_pkg::*;

    // input stage
    logic        r_in_valid;
    logic [2:0]  r_command;
    logic [7:0]  r_write_data;
    logic        r_bus_level;

    // output stage
    logic        r_out_valid;
    t_result     r_result;

    t_cfg        cfg;
    t_result     step_result;
    logic        advance;
    logic        in_ready;

    // step the held tick when the output slot is free or draining
    assign advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_command    <= i_command;
            r_write_data <= i_write_data;
            r_bus_level  <= i_bus_level;
        end
    end

    ows_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ows_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_command    (r_command),
        .i_write_data (r_write_data),
        .i_bus_level  (r_bus_level),
        .i_cfg        (cfg),
        .o_result     (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_drive_low = r_result.drive_low;
    assign o_busy_res  = r_result.busy_res;
    assign o_done_res  = r_result.done_res;
    assign o_presence  = r_result.presence;
    assign o_read_data = r_result.read_data;

endmodule

`default_nettype wire

### rtl/ows_cfg_regs.sv
`default_nettype none

module ows_cfg_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [9:0]   i_cfg_data,
    output ows_pkg::t_cfg     o_cfg
);
    import ows_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks         <= 10'd480;
            r_cfg.presence_interval_ticks <= 8'd60;
            r_cfg.presence_recovery_ticks <= 10'd420;
            r_cfg.write_zero_low_ticks    <= 8'd60;
            r_cfg.write_one_low_ticks     <= 8'd5;
            r_cfg.write_one_tail_ticks    <= 8'd60;
            r_cfg.read_sample_ticks       <= 8'd10;
            r_cfg.read_tail_ticks         <= 8'd70;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RESET_LOW:     r_cfg.reset_low_ticks         <= i_cfg_data;
                CFG_PRES_INTERVAL: r_cfg.presence_interval_ticks <= i_cfg_data[7:0];
                CFG_PRES_RECOVERY: r_cfg.presence_recovery_ticks <= i_cfg_data;
                CFG_W0_LOW:        r_cfg.write_zero_low_ticks    <= i_cfg_data[7:0];
                CFG_W1_LOW:        r_cfg.write_one_low_ticks     <= i_cfg_data[7:0];
                CFG_W1_TAIL:       r_cfg.write_one_tail_ticks    <= i_cfg_data[7:0];
                CFG_RD_SAMPLE:     r_cfg.read_sample_ticks       <= i_cfg_data[7:0];
                CFG_RD_TAIL:       r_cfg.read_tail_ticks         <= i_cfg_data[7:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/ows_step.sv
`default_nettype none

// One tick of the bus sequencer: next state and this tick's result.
module ows_step (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_advance,
    input  wire logic [2:0]   i_command,
    input  wire logic [7:0]   i_write_data,
    input  wire logic         i_bus_level,
    input  wire ows_pkg::t_cfg i_cfg,
    output ows_pkg::t_result  o_result
);
    import ows_pkg::*;

    t_phase       r_phase,  n_phase;
    logic [9:0]   r_timer,  n_timer;
    logic [3:0]   r_bitcnt, n_bitcnt;
    logic [7:0]   r_shift,  n_shift;
    logic [2:0]   r_tries,  n_tries;
    logic         r_pres,   n_pres;
    logic [7:0]   r_rdata,  n_rdata;
    logic         r_bmode,  n_bmode;

    logic         drive;
    logic         busy;
    logic         done;

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_bitcnt = r_bitcnt;
        n_shift  = r_shift;
        n_tries  = r_tries;
        n_pres   = r_pres;
        n_rdata  = r_rdata;
        n_bmode  = r_bmode;
        drive    = 1'b0;
        busy     = 1'b0;
        done     = 1'b0;

        // command start, only from idle
        if (r_phase == PH_IDLE && i_command >= CMD_RESET && i_command <= CMD_WRITE_BIT) begin
            n_bitcnt = '0;
            if (i_command == CMD_RESET) begin
                n_pres  = 1'b0;
                n_tries = '0;
                n_phase = PH_RST_LOW;
                n_timer = span(i_cfg.reset_low_ticks);
            end else if (i_command == CMD_WRITE_BYTE || i_command == CMD_WRITE_BIT) begin
                n_bmode = (i_command == CMD_WRITE_BYTE);
                n_shift = n_bmode ? i_write_data : {7'd0, i_write_data[0]};
                if (n_shift[0]) begin
                    n_phase = PH_W1_LOW;
                    n_timer = span({2'd0, i_cfg.write_one_low_ticks});
                end else begin
                    n_phase = PH_W0_LOW;
                    n_timer = span({2'd0, i_cfg.write_zero_low_ticks});
                end
            end else begin
                n_bmode = (i_command == CMD_READ_BYTE);
                n_shift = '0;
                n_phase = PH_RD_LOW;
                n_timer = 10'(READ_LOW_TICKS);
            end
        end

        if (n_phase != PH_IDLE) begin
            busy  = 1'b1;
            drive = (n_phase == PH_RST_LOW) || (n_phase == PH_W0_LOW) ||
                    (n_phase == PH_W1_LOW) || (n_phase == PH_RD_LOW);
            n_timer = (n_timer != '0) ? n_timer - 10'd1 : '0;
            if (n_timer == '0) begin
                unique case (n_phase)
                    PH_RST_LOW: begin
                        n_phase = PH_PRES_WAIT;
                        n_timer = span({2'd0, i_cfg.presence_interval_ticks});
                    end
                    PH_PRES_WAIT: begin
                        if (!i_bus_level) begin
                            n_pres  = 1'b1;
                            n_phase = PH_PRES_REC;
                            n_timer = span(i_cfg.presence_recovery_ticks);
                        end else begin
                            n_tries = n_tries + 3'd1;
                            if (n_tries >= 3'(PRESENCE_TRIES)) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_phase = PH_PRES_WAIT;
                                n_timer = span({2'd0, i_cfg.presence_interval_ticks});
                            end
                        end
                    end
                    PH_PRES_REC: begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                    PH_W0_LOW, PH_W1_TAIL: begin
                        n_bitcnt = n_bitcnt + 4'd1;
                        n_shift  = {1'b0, n_shift[7:1]};
                        if (!n_bmode || n_bitcnt[3]) begin
                            n_phase = PH_IDLE;
                            n_timer = '0;
                            done    = 1'b1;
                        end else if (n_shift[0]) begin
                            n_phase = PH_W1_LOW;
                            n_timer = span({2'd0, i_cfg.write_one_low_ticks});
                        end else begin
                            n_phase = PH_W0_LOW;
                            n_timer = span({2'd0, i_cfg.write_zero_low_ticks});
                        end
                    end
                    PH_W1_LOW: begin
                        n_phase = PH_W1_TAIL;
                        n_timer = span({2'd0, i_cfg.write_one_tail_ticks});
                    end
                    PH_RD_LOW: begin
                        n_phase = PH_RD_WAIT;
                        n_timer = span({2'd0, i_cfg.read_sample_ticks});
                    end
                    PH_RD_WAIT: begin
                        n_shift = n_bmode ? {i_bus_level, n_shift[7:1]}
                                          : {7'd0, i_bus_level};
                        n_phase = PH_RD_TAIL;
                        n_timer = span({2'd0, i_cfg.read_tail_ticks});
                    end
                    PH_RD_TAIL: begin
                        n_bitcnt = n_bitcnt + 4'd1;
                        if (!n_bmode || n_bitcnt[3]) begin
                            n_rdata = n_shift;
                            n_phase = PH_IDLE;
                            n_timer = '0;
                            done    = 1'b1;
                        end else begin
                            n_phase = PH_RD_LOW;
                            n_timer = 10'(READ_LOW_TICKS);
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= '0;
            r_bitcnt <= '0;
            r_shift  <= '0;
            r_tries  <= '0;
            r_pres   <= 1'b0;
            r_rdata  <= '0;
            r_bmode  <= 1'b0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_bitcnt <= n_bitcnt;
            r_shift  <= n_shift;
            r_tries  <= n_tries;
            r_pres   <= n_pres;
            r_rdata  <= n_rdata;
            r_bmode  <= n_bmode;
        end
    end

    assign o_result.drive_low = drive;
    assign o_result.busy_res  = busy;
    assign o_result.done_res  = done;
    assign o_result.presence  = n_pres;
    assign o_result.read_data = n_rdata;

endmodule

`default_nettype wire
